[hdl/lsc_pkg.sv]
// Shared types, constants and helpers for the line segment rectangle clipper.
package lsc_pkg;

	localparam int COORD_W  = 32;              // coordinate width, Q16.16
	localparam int T_FRAC   = 24;              // fraction bits of the parameter t
	localparam int MAG_W    = COORD_W + 1;     // width of a difference or its magnitude
	localparam int T_W      = T_FRAC + 1;      // t in [0, 1.0]
	localparam int RES_W    = T_FRAC + 2;      // quotient magnitude, up to 2.0
	localparam int R_W      = T_FRAC + 3;      // signed quotient
	localparam int PROD_W   = MAG_W + T_W;     // |d| * t
	localparam int N_EDGE   = 4;
	localparam int DIV_LAT  = T_FRAC + 1;      // saturation plus integer bit, then one bit a stage
	localparam int EDGE_LAT = N_EDGE + 1;      // sign stage, then one stage per edge test

	localparam logic [RES_W-1:0] SAT_Q = RES_W'(2) << T_FRAC;
	localparam logic [T_W-1:0]   T_ONE = T_W'(1) << T_FRAC;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [MAG_W-1:0]   diff_t;
	typedef logic [MAG_W-1:0]          mag_t;

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_BOTTOM = 2'd1,
		REG_RIGHT  = 2'd2,
		REG_TOP    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by_coord;
	} seg_t;

	typedef struct packed {
		logic   visible;
		coord_t clip_ax;
		coord_t clip_ay;
		coord_t clip_bx;
		coord_t clip_by;
	} res_t;

	typedef struct packed {
		logic pzero;
		logic qneg;
		logic pneg;
		logic neg;    // quotient sign
	} edge_flag_t;

	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		mag_t   mdx;
		mag_t   mdy;
		logic   dxneg;
		logic   dyneg;
	} side_t;

	typedef struct packed {
		logic           vis;
		logic [T_W-1:0] t0;
		logic [T_W-1:0] t1;
	} tpar_t;

	function automatic diff_t sx(input coord_t c);
		return {c[COORD_W-1], c};
	endfunction

	function automatic mag_t mag(input diff_t v);
		diff_t n;
		n = -v;
		return v[MAG_W-1] ? $unsigned(n) : $unsigned(v);
	endfunction

endpackage

[hdl/line_segment_rect_clip.sv]
// Top level of the Liang-Barsky line segment clipper against a configured window.
//
//  channel   signals                               direction  handshake
//  segment   start, busy, seg                      in         start & !busy
//  result    done, res                             out        done, one cycle
//  config    cfg_valid, cfg_ready, cfg_index,      in         cfg_valid & cfg_ready
//            cfg_data
//
// One segment per cycle; each segment passes the input registers, the divider lanes
// that resolve one quotient bit a stage, the edge test stages and the interpolator.
// busy stays low and cfg_ready stays high: the pipeline never stalls.
// Reset clears the valid bits and sets the window to zero.
module line_segment_rect_clip (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  lsc_pkg::seg_t          seg,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  lsc_pkg::coord_t        cfg_data,
	output logic                   done,
	output lsc_pkg::res_t          res
);

	localparam int SIDE_LAT = lsc_pkg::DIV_LAT + lsc_pkg::EDGE_LAT;
	localparam int LAT      = SIDE_LAT + 5;

	lsc_pkg::coord_t win_q [lsc_pkg::N_EDGE];

	logic                 vld_s1, vld_s2, vld_s3;
	lsc_pkg::seg_t        seg_s1;
	lsc_pkg::diff_t       p_s2 [lsc_pkg::N_EDGE];
	lsc_pkg::diff_t       q_s2 [lsc_pkg::N_EDGE];
	lsc_pkg::coord_t      x0_s2, y0_s2, x1_s2, y1_s2;
	lsc_pkg::mag_t        mq_s3 [lsc_pkg::N_EDGE];
	lsc_pkg::mag_t        mp_s3 [lsc_pkg::N_EDGE];
	lsc_pkg::edge_flag_t  flag_s3 [lsc_pkg::N_EDGE];
	lsc_pkg::side_t       side_s3;

	lsc_pkg::side_t       side_pipe_s [SIDE_LAT];
	logic                 vld_pipe_s  [SIDE_LAT];

	logic [lsc_pkg::N_EDGE-1:0][lsc_pkg::RES_W-1:0] dres;
	lsc_pkg::edge_flag_t [lsc_pkg::N_EDGE-1:0]      dflag;
	lsc_pkg::tpar_t                                 tpar;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lsc_pkg::N_EDGE; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (lsc_pkg::cfg_reg_t'(cfg_index))
				lsc_pkg::REG_LEFT:   win_q[lsc_pkg::REG_LEFT]   <= cfg_data;
				lsc_pkg::REG_BOTTOM: win_q[lsc_pkg::REG_BOTTOM] <= cfg_data;
				lsc_pkg::REG_RIGHT:  win_q[lsc_pkg::REG_RIGHT]  <= cfg_data;
				lsc_pkg::REG_TOP:    win_q[lsc_pkg::REG_TOP]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int i = 0; i < SIDE_LAT; i++) begin
				vld_pipe_s[i] <= 1'b0;
			end
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_pipe_s[0] <= vld_s3;
			for (int i = 1; i < SIDE_LAT; i++) begin
				vld_pipe_s[i] <= vld_pipe_s[i-1];
			end
		end
	end

	// capture word, form direction and distance terms, then magnitudes
	always_ff @(posedge clk) begin
		seg_s1 <= seg;

		p_s2[0] <= lsc_pkg::sx(seg_s1.ax) - lsc_pkg::sx(seg_s1.bx);
		q_s2[0] <= lsc_pkg::sx(seg_s1.ax) - lsc_pkg::sx(win_q[lsc_pkg::REG_LEFT]);
		p_s2[1] <= lsc_pkg::sx(seg_s1.bx) - lsc_pkg::sx(seg_s1.ax);
		q_s2[1] <= lsc_pkg::sx(win_q[lsc_pkg::REG_RIGHT]) - lsc_pkg::sx(seg_s1.ax);
		p_s2[2] <= lsc_pkg::sx(seg_s1.ay) - lsc_pkg::sx(seg_s1.by_coord);
		q_s2[2] <= lsc_pkg::sx(seg_s1.ay) - lsc_pkg::sx(win_q[lsc_pkg::REG_BOTTOM]);
		p_s2[3] <= lsc_pkg::sx(seg_s1.by_coord) - lsc_pkg::sx(seg_s1.ay);
		q_s2[3] <= lsc_pkg::sx(win_q[lsc_pkg::REG_TOP]) - lsc_pkg::sx(seg_s1.ay);
		x0_s2   <= seg_s1.ax;
		y0_s2   <= seg_s1.ay;
		x1_s2   <= seg_s1.bx;
		y1_s2   <= seg_s1.by_coord;

		for (int k = 0; k < lsc_pkg::N_EDGE; k++) begin
			mq_s3[k]         <= lsc_pkg::mag(q_s2[k]);
			mp_s3[k]         <= lsc_pkg::mag(p_s2[k]);
			flag_s3[k].pzero <= p_s2[k] == '0;
			flag_s3[k].qneg  <= q_s2[k][lsc_pkg::MAG_W-1];
			flag_s3[k].pneg  <= p_s2[k][lsc_pkg::MAG_W-1];
			flag_s3[k].neg   <= q_s2[k][lsc_pkg::MAG_W-1] ^ p_s2[k][lsc_pkg::MAG_W-1];
		end
		side_s3.x0    <= x0_s2;
		side_s3.y0    <= y0_s2;
		side_s3.x1    <= x1_s2;
		side_s3.y1    <= y1_s2;
		side_s3.mdx   <= lsc_pkg::mag(p_s2[1]);
		side_s3.mdy   <= lsc_pkg::mag(p_s2[3]);
		side_s3.dxneg <= p_s2[1][lsc_pkg::MAG_W-1];
		side_s3.dyneg <= p_s2[3][lsc_pkg::MAG_W-1];

		side_pipe_s[0] <= side_s3;
		for (int i = 1; i < SIDE_LAT; i++) begin
			side_pipe_s[i] <= side_pipe_s[i-1];
		end
	end

	for (genvar k = 0; k < lsc_pkg::N_EDGE; k++) begin : g_div
		lsc_div u_div (
			.clk      (clk),
			.mq       (mq_s3[k]),
			.mp       (mp_s3[k]),
			.flag_in  (flag_s3[k]),
			.res      (dres[k]),
			.flag_out (dflag[k])
		);
	end

	lsc_edge u_edge (
		.clk  (clk),
		.res  (dres),
		.flag (dflag),
		.tpar (tpar)
	);

	lsc_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_pipe_s[SIDE_LAT-1]),
		.side   (side_pipe_s[SIDE_LAT-1]),
		.tpar   (tpar),
		.done   (done),
		.res    (res)
	);

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted segment did not produce a result on time");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching segment");

	a_reject_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.visible |-> res.clip_ax == $past(seg.ax, LAT)
			&& res.clip_by == $past(seg.by_coord, LAT))
		else $error("rejected segment did not pass endpoints through");

	a_vertical: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.visible && $past(seg.ax, LAT) == $past(seg.bx, LAT)
		|-> res.clip_ax == $past(seg.ax, LAT) && res.clip_bx == $past(seg.ax, LAT))
		else $error("vertical segment moved in x");

endmodule

[hdl/lsc_div.sv]
// Pipelined restoring divider lane: |q| / |p| to T_FRAC fraction bits, capped at 2.0.
module lsc_div (
	input  logic                          clk,
	input  lsc_pkg::mag_t                 mq,
	input  lsc_pkg::mag_t                 mp,
	input  lsc_pkg::edge_flag_t           flag_in,
	output logic [lsc_pkg::RES_W-1:0]     res,
	output lsc_pkg::edge_flag_t           flag_out
);

	lsc_pkg::mag_t               rem_s  [lsc_pkg::DIV_LAT];
	lsc_pkg::mag_t               mp_s   [lsc_pkg::DIV_LAT];
	logic [lsc_pkg::T_W-1:0]     qb_s   [lsc_pkg::DIV_LAT];
	logic                        sat_s  [lsc_pkg::DIV_LAT];
	lsc_pkg::edge_flag_t         flag_s [lsc_pkg::DIV_LAT];

	logic          sat0, ge0;
	lsc_pkg::mag_t rem0;

	// first stage settles saturation and the integer bit together
	always_comb begin
		sat0 = {1'b0, mq} >= {mp, 1'b0};
		ge0  = mq >= mp;
		rem0 = ge0 ? mq - mp : mq;
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= rem0;
		mp_s[0]   <= mp;
		qb_s[0]   <= lsc_pkg::T_W'(ge0);
		sat_s[0]  <= sat0;
		flag_s[0] <= flag_in;
	end

	for (genvar i = 1; i < lsc_pkg::DIV_LAT; i++) begin : g_step
		logic [lsc_pkg::MAG_W:0] r2, diff;
		logic                    ge;
		always_comb begin
			r2   = {rem_s[i-1], 1'b0};
			diff = r2 - {1'b0, mp_s[i-1]};
			ge   = r2 >= {1'b0, mp_s[i-1]};
		end
		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? diff[lsc_pkg::MAG_W-1:0] : r2[lsc_pkg::MAG_W-1:0];
			mp_s[i]   <= mp_s[i-1];
			qb_s[i]   <= {qb_s[i-1][lsc_pkg::T_W-2:0], ge};
			sat_s[i]  <= sat_s[i-1];
			flag_s[i] <= flag_s[i-1];
		end
	end

	assign res      = sat_s[lsc_pkg::DIV_LAT-1] ? lsc_pkg::SAT_Q
	                                            : {1'b0, qb_s[lsc_pkg::DIV_LAT-1]};
	assign flag_out = flag_s[lsc_pkg::DIV_LAT-1];

endmodule

[hdl/lsc_edge.sv]
// Edge test pipeline: signs the quotients, then tightens t0/t1 one edge per stage.
module lsc_edge (
	input  logic                                          clk,
	input  logic [lsc_pkg::N_EDGE-1:0][lsc_pkg::RES_W-1:0] res,
	input  lsc_pkg::edge_flag_t [lsc_pkg::N_EDGE-1:0]      flag,
	output lsc_pkg::tpar_t                                 tpar
);

	typedef struct packed {
		logic [lsc_pkg::N_EDGE-1:0][lsc_pkg::R_W-1:0] r;
		lsc_pkg::edge_flag_t [lsc_pkg::N_EDGE-1:0]    flag;
		logic [lsc_pkg::T_W-1:0]                      t0;
		logic [lsc_pkg::T_W-1:0]                      t1;
		logic                                         ok;
	} edge_st_t;

	edge_st_t e_s [lsc_pkg::EDGE_LAT];
	edge_st_t e0;

	always_comb begin
		e0 = '0;
		for (int k = 0; k < lsc_pkg::N_EDGE; k++) begin
			e0.r[k] = flag[k].neg ? -{1'b0, res[k]} : {1'b0, res[k]};
		end
		e0.flag = flag;
		e0.t0   = '0;
		e0.t1   = lsc_pkg::T_ONE;
		e0.ok   = 1'b1;
	end

	always_ff @(posedge clk) begin
		e_s[0] <= e0;
	end

	for (genvar k = 0; k < lsc_pkg::N_EDGE; k++) begin : g_test
		edge_st_t                        nx;
		logic signed [lsc_pkg::R_W-1:0]  rk, t0s, t1s;
		always_comb begin
			nx  = e_s[k];
			rk  = $signed(e_s[k].r[k]);
			t0s = $signed({2'b00, e_s[k].t0});
			t1s = $signed({2'b00, e_s[k].t1});
			if (e_s[k].ok) begin
				priority if (e_s[k].flag[k].pzero) begin
					nx.ok = !e_s[k].flag[k].qneg;
				end else if (e_s[k].flag[k].pneg) begin
					if (rk > t1s) begin
						nx.ok = 1'b0;
					end else if (rk > t0s) begin
						nx.t0 = rk[lsc_pkg::T_W-1:0];
					end
				end else begin
					if (rk < t0s) begin
						nx.ok = 1'b0;
					end else if (rk < t1s) begin
						nx.t1 = rk[lsc_pkg::T_W-1:0];
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			e_s[k+1] <= nx;
		end
	end

	assign tpar.vis = e_s[lsc_pkg::EDGE_LAT-1].ok;
	assign tpar.t0  = e_s[lsc_pkg::EDGE_LAT-1].t0;
	assign tpar.t1  = e_s[lsc_pkg::EDGE_LAT-1].t1;

endmodule

[hdl/lsc_lerp.sv]
// Endpoint interpolation: multiply stage, then add stage and result register.
module lsc_lerp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  lsc_pkg::side_t  side,
	input  lsc_pkg::tpar_t  tpar,
	output logic            done,
	output lsc_pkg::res_t   res
);

	logic                       vld_s1;
	lsc_pkg::side_t             side_s1;
	logic                       vis_s1;
	logic [lsc_pkg::PROD_W-1:0] pax_s1, pay_s1, pbx_s1, pby_s1;

	function automatic lsc_pkg::coord_t step(input lsc_pkg::coord_t x, input logic neg,
	                                         input logic [lsc_pkg::PROD_W-1:0] p);
		logic signed [lsc_pkg::COORD_W+2:0] xe, pe, s;
		xe = {{3{x[lsc_pkg::COORD_W-1]}}, x};
		pe = $signed({1'b0, p[lsc_pkg::PROD_W-1:lsc_pkg::T_FRAC]});
		s  = neg ? xe - pe : xe + pe;
		return s[lsc_pkg::COORD_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= vld;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side;
		vis_s1  <= tpar.vis;
		pax_s1  <= lsc_pkg::PROD_W'(side.mdx) * lsc_pkg::PROD_W'(tpar.t0);
		pay_s1  <= lsc_pkg::PROD_W'(side.mdy) * lsc_pkg::PROD_W'(tpar.t0);
		pbx_s1  <= lsc_pkg::PROD_W'(side.mdx) * lsc_pkg::PROD_W'(tpar.t1);
		pby_s1  <= lsc_pkg::PROD_W'(side.mdy) * lsc_pkg::PROD_W'(tpar.t1);
	end

	// rejected segments pass their endpoints through
	always_ff @(posedge clk) begin
		res.visible <= vis_s1;
		if (vis_s1) begin
			res.clip_ax <= step(side_s1.x0, side_s1.dxneg, pax_s1);
			res.clip_ay <= step(side_s1.y0, side_s1.dyneg, pay_s1);
			res.clip_bx <= step(side_s1.x0, side_s1.dxneg, pbx_s1);
			res.clip_by <= step(side_s1.y0, side_s1.dyneg, pby_s1);
		end else begin
			res.clip_ax <= side_s1.x0;
			res.clip_ay <= side_s1.y0;
			res.clip_bx <= side_s1.x1;
			res.clip_by <= side_s1.y1;
		end
	end

endmodule

[dv/tb.sv]
// Self-checking testbench for the line segment rectangle clipper.
`timescale 1ns / 100ps

module tb;

	localparam lsc_pkg::coord_t CMIN = 32'sh8000_0000;
	localparam lsc_pkg::coord_t CMAX = 32'sh7fff_ffff;
	localparam int              DRAIN = lsc_pkg::T_FRAC + 20;

	logic            clk, arst_n;
	logic            start, busy, done;
	lsc_pkg::seg_t   seg;
	lsc_pkg::res_t   res;
	logic            cfg_valid, cfg_ready;
	logic [1:0]      cfg_index;
	lsc_pkg::coord_t cfg_data;

	line_segment_rect_clip i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .seg(seg),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .res(res)
	);

	// window as the predictor sees it
	lsc_pkg::coord_t win_l, win_b, win_r, win_t;
	lsc_pkg::res_t   clip_q[$];
	int              errors, n_vis, n_rej, n_seg;
	bit              burst;

	typedef struct {
		int            w;
		lsc_pkg::seg_t s;
		bit            lit;
		lsc_pkg::res_t r;
	} row_t;
	row_t            rows[$];
	lsc_pkg::coord_t wins[4][4];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("timeout with %0d words outstanding", clip_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic lsc_pkg::coord_t fx(int n);
		return lsc_pkg::coord_t'(n) <<< 16;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// q/p in Q.T_FRAC, truncated toward zero, capped at 2.0
	function automatic longint edge_ratio(longint q, longint p);
		longint unsigned mq, mp, iq, rem, frac, r;
		mq = q < 0 ? -q : q;
		mp = p < 0 ? -p : p;
		iq = mq / mp;
		if (iq >= 2) begin
			r = 64'd2 << lsc_pkg::T_FRAC;
		end else begin
			rem = mq - iq * mp;
			frac = 0;
			for (int i = 0; i < lsc_pkg::T_FRAC; i++) begin
				rem = rem << 1;
				frac = frac << 1;
				if (rem >= mp) begin
					rem -= mp;
					frac |= 1;
				end
			end
			r = (iq << lsc_pkg::T_FRAC) | frac;
		end
		return ((q < 0) != (p < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic bit edge_pass(longint p, longint q, ref longint t0, ref longint t1);
		longint r;
		if (p == 0)
			return q >= 0;
		r = edge_ratio(q, p);
		if (p < 0) begin
			if (r > t1) return 0;
			if (r > t0) t0 = r;
		end else begin
			if (r < t0) return 0;
			if (r < t1) t1 = r;
		end
		return 1;
	endfunction

	function automatic lsc_pkg::coord_t interp(longint x, longint d, longint t);
		longint unsigned m, prod;
		m = d < 0 ? -d : d;
		prod = (m * longint'(t)) >> lsc_pkg::T_FRAC;
		return lsc_pkg::coord_t'(d < 0 ? x - longint'(prod) : x + longint'(prod));
	endfunction

	function automatic lsc_pkg::res_t clip_segment(lsc_pkg::seg_t s);
		longint x0, y0, x1, y1, dx, dy, t0, t1;
		lsc_pkg::res_t r;
		bit v;
		x0 = s.ax; y0 = s.ay; x1 = s.bx; y1 = s.by_coord;
		dx = x1 - x0; dy = y1 - y0;
		t0 = 0; t1 = longint'(1) << lsc_pkg::T_FRAC;
		v = edge_pass(-dx, x0 - longint'(win_l), t0, t1)
			&& edge_pass(dx, longint'(win_r) - x0, t0, t1)
			&& edge_pass(-dy, y0 - longint'(win_b), t0, t1)
			&& edge_pass(dy, longint'(win_t) - y0, t0, t1);
		r = '{1'b0, s.ax, s.ay, s.bx, s.by_coord};
		if (v)
			r = '{1'b1, interp(x0, dx, t0), interp(y0, dy, t0),
				interp(x0, dx, t1), interp(y0, dy, t1)};
		return r;
	endfunction

	task automatic write_window_reg(lsc_pkg::cfg_reg_t idx, lsc_pkg::coord_t v);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lsc_pkg::REG_LEFT:   win_l = v;
			lsc_pkg::REG_BOTTOM: win_b = v;
			lsc_pkg::REG_RIGHT:  win_r = v;
			default:             win_t = v;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// wait for the pipe to drain, then load a new window, starting at a random register
	task automatic load_window(lsc_pkg::coord_t l, lsc_pkg::coord_t b,
	                           lsc_pkg::coord_t r, lsc_pkg::coord_t t);
		int k;
		wait (clip_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		k = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			case (lsc_pkg::cfg_reg_t'((i + k) % 4))
				lsc_pkg::REG_LEFT:   write_window_reg(lsc_pkg::REG_LEFT, l);
				lsc_pkg::REG_BOTTOM: write_window_reg(lsc_pkg::REG_BOTTOM, b);
				lsc_pkg::REG_RIGHT:  write_window_reg(lsc_pkg::REG_RIGHT, r);
				default:             write_window_reg(lsc_pkg::REG_TOP, t);
			endcase
		end
	endtask

	// hold start until the word is taken; expectation comes from lit or the predictor
	task automatic send_segment(lsc_pkg::seg_t s, bit lit, lsc_pkg::res_t r);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			start = 0;
		end
		@(negedge clk);
		start = 1;
		seg = s;
		do @(posedge clk); while (busy);
		clip_q.insert(clip_q.size(), lit ? r : clip_segment(s));
		n_seg++;
	endtask

	function automatic lsc_pkg::coord_t near_edge(lsc_pkg::coord_t e);
		case ($urandom_range(0, 3))
			0: return e;
			1: return e + lsc_pkg::coord_t'($urandom_range(0, 8)) - 4;
			2: return e + (lsc_pkg::coord_t'($urandom) >>> $urandom_range(8, 31));
			default: return lsc_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic lsc_pkg::seg_t rand_segment();
		lsc_pkg::seg_t s;
		case ($urandom_range(0, 9))
			0: s = {$urandom, $urandom, $urandom, $urandom};
			1: begin
				s.ax = near_edge(win_l); s.bx = near_edge(win_r);
				s.ay = near_edge(win_b); s.by_coord = s.ay;
			end
			2: begin
				s.ay = near_edge(win_b); s.by_coord = near_edge(win_t);
				s.ax = near_edge(win_r); s.bx = s.ax;
			end
			3: begin
				s.ax = near_edge($urandom_range(0, 1) ? win_l : win_r);
				s.ay = near_edge($urandom_range(0, 1) ? win_b : win_t);
				s.bx = s.ax; s.by_coord = s.ay;
			end
			4: s = {$urandom_range(0, 1) ? CMIN : CMAX, $urandom_range(0, 1) ? CMIN : CMAX,
				$urandom_range(0, 1) ? CMIN : CMAX, $urandom_range(0, 1) ? CMIN : CMAX};
			default: begin
				s.ax = near_edge($urandom_range(0, 1) ? win_l : win_r);
				s.ay = near_edge($urandom_range(0, 1) ? win_b : win_t);
				s.bx = near_edge($urandom_range(0, 1) ? win_l : win_r);
				s.by_coord = near_edge($urandom_range(0, 1) ? win_b : win_t);
			end
		endcase
		return s;
	endfunction

	function automatic void add_row(int w, lsc_pkg::seg_t s, bit lit, lsc_pkg::res_t r);
		rows.insert(rows.size(), row_t'{w, s, lit, r});
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (clip_q.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				lsc_pkg::res_t e;
				e = clip_q.pop_front();
				if (res.visible !== e.visible)
					report_mismatch($sformatf("visible %b, want %b", res.visible, e.visible));
				if (res.clip_ax !== e.clip_ax)
					report_mismatch($sformatf("clip_ax %h, want %h", res.clip_ax, e.clip_ax));
				if (res.clip_ay !== e.clip_ay)
					report_mismatch($sformatf("clip_ay %h, want %h", res.clip_ay, e.clip_ay));
				if (res.clip_bx !== e.clip_bx)
					report_mismatch($sformatf("clip_bx %h, want %h", res.clip_bx, e.clip_bx));
				if (res.clip_by !== e.clip_by)
					report_mismatch($sformatf("clip_by %h, want %h", res.clip_by, e.clip_by));
				if (e.visible) n_vis++;
				else n_rej++;
			end
		end
	end

	initial begin
		int cur;
		lsc_pkg::coord_t l, b, r, t, u, v;
		lsc_pkg::seg_t s;
		errors = 0; n_vis = 0; n_rej = 0; n_seg = 0;
		start = 0; seg = '0; cfg_valid = 0; cfg_index = lsc_pkg::REG_LEFT; cfg_data = '0;
		win_l = 0; win_b = 0; win_r = 0; win_t = 0;
		burst = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		wins[0] = '{0, 0, 0, 0};
		wins[1] = '{fx(-100), fx(-50), fx(100), fx(50)};
		wins[2] = '{CMIN, CMIN, CMAX, CMAX};
		wins[3] = '{fx(100), fx(50), fx(-100), fx(-50)};

		// reset window: a closed point at the origin
		add_row(0, '{0, 0, 0, 0}, 1, '{1, 0, 0, 0, 0});
		add_row(0, '{fx(1), fx(1), fx(1), fx(1)}, 1, '{0, fx(1), fx(1), fx(1), fx(1)});
		add_row(0, '{CMIN, 0, CMAX, 0}, 0, '0);
		// fully inside, outside, crossing, parallel outside, corner point
		add_row(1, '{fx(10), fx(5), fx(-20), fx(-7)}, 1,
			'{1, fx(10), fx(5), fx(-20), fx(-7)});
		add_row(1, '{fx(-200), 0, fx(-150), fx(10)}, 1,
			'{0, fx(-200), 0, fx(-150), fx(10)});
		add_row(1, '{fx(-200), 0, fx(200), 0}, 1, '{1, fx(-100), 0, fx(100), 0});
		add_row(1, '{fx(-200), fx(60), fx(200), fx(60)}, 1,
			'{0, fx(-200), fx(60), fx(200), fx(60)});
		add_row(1, '{fx(100), fx(50), fx(100), fx(50)}, 1,
			'{1, fx(100), fx(50), fx(100), fx(50)});
		add_row(1, '{0, fx(-80), 0, fx(80)}, 0, '0);
		add_row(1, '{fx(101), 0, fx(101), 0}, 0, '0);
		add_row(1, '{fx(-300), fx(-200), fx(300), fx(200)}, 0, '0);
		add_row(1, '{fx(-7), fx(3), fx(250), fx(-90)}, 0, '0);
		add_row(1, '{CMIN, CMIN, CMAX, CMAX}, 0, '0);
		add_row(1, '{CMAX, CMAX, CMIN, CMIN}, 0, '0);
		add_row(1, '{CMAX, CMIN, CMIN, CMAX}, 0, '0);
		add_row(1, '{-1, -1, 1, 1}, 0, '0);
		add_row(2, '{CMIN, CMIN, CMAX, CMAX}, 1, '{1, CMIN, CMIN, CMAX, CMAX});
		add_row(2, '{CMAX, CMIN, CMIN, CMAX}, 1, '{1, CMAX, CMIN, CMIN, CMAX});
		add_row(2, '{CMAX, 0, CMAX, 0}, 0, '0);
		add_row(3, '{0, 0, 0, 0}, 0, '0);
		add_row(3, '{fx(-200), 0, fx(200), 0}, 0, '0);
		add_row(3, '{CMIN, CMIN, CMAX, CMAX}, 0, '0);

		cur = 0;
		foreach (rows[i]) begin
			if (rows[i].w != cur) begin
				@(negedge clk);
				start = 0;
				cur = rows[i].w;
				load_window(wins[cur][0], wins[cur][1], wins[cur][2], wins[cur][3]);
			end
			send_segment(rows[i].s, rows[i].lit, rows[i].r);
		end

		for (int ph = 0; ph < 7; ph++) begin
			@(negedge clk);
			start = 0;
			case (ph)
				0: begin l = CMIN; b = CMIN; r = CMAX; t = CMAX; end
				1: begin l = 0; b = 0; r = 0; t = 0; end
				2: begin l = fx(30); b = fx(20); r = fx(-30); t = fx(-20); end
				3: begin
					u = $urandom; v = $urandom;
					l = u < v ? u : v; r = u < v ? v : u;
					u = $urandom; v = $urandom;
					b = u < v ? u : v; t = u < v ? v : u;
				end
				default: begin
					l = lsc_pkg::coord_t'($urandom) >>> $urandom_range(4, 20);
					b = lsc_pkg::coord_t'($urandom) >>> $urandom_range(4, 20);
					r = l + (lsc_pkg::coord_t'($urandom_range(0, 32'h7fff_ffff))
						>>> $urandom_range(1, 20));
					t = b + (lsc_pkg::coord_t'($urandom_range(0, 32'h7fff_ffff))
						>>> $urandom_range(1, 20));
				end
			endcase
			load_window(l, b, r, t);
			for (int n = 0; n < 200; n++) begin
				if (n % 50 == 0)
					burst = $urandom_range(0, 3) == 0;
				s = rand_segment();
				send_segment(s, 0, '0);
			end
			burst = 0;
		end
		@(negedge clk);
		start = 0;

		wait (clip_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		$display("%0d segments over 11 window settings: %0d visible, %0d rejected",
			n_seg, n_vis, n_rej);
		$display("%0d mismatches", errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
hdl/lsc_pkg.sv
hdl/lsc_div.sv
hdl/lsc_edge.sv
hdl/lsc_lerp.sv
hdl/line_segment_rect_clip.sv
dv/tb.sv
